FILE: src/mlp_pkg.sv
// Shared constants, types and the sigmoid lookup table for the two-layer perceptron core.
// No dependencies. Imported by every module under src.
package mlp_pkg;

    localparam int IN_DIM   = 256;
    localparam int HIDDEN   = 32;
    localparam int CLASSES  = 16;
    localparam int HW_DEPTH = HIDDEN * (IN_DIM + 1);
    localparam int OW_DEPTH = CLASSES * (HIDDEN + 1);

    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 14;
    localparam int W_W      = 16;
    localparam int PIX_W    = 8;
    localparam int CIDX_W   = 4;
    localparam int ACT_W    = 8;
    localparam int SUM_W    = 32;
    localparam int Q_W      = SUM_W - 4;
    localparam int SC_W     = 32;

    localparam int HW_AW    = $clog2(HW_DEPTH);
    localparam int OW_AW    = $clog2(OW_DEPTH);
    localparam int POS_W    = $clog2(IN_DIM + 1);
    localparam int HID_W    = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
    localparam int J_W      = $clog2(HIDDEN + 1);
    localparam int CLS_W    = $clog2(CLASSES);

    localparam logic [KIND_W-1:0] KIND_HW  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OW  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PIX = 2'd2;

    localparam logic [63:0] EXP_STEP = 64'd4034748382;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ACT,
        ST_SCORE,
        ST_SETTLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mac;
        logic act;
        logic score;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic h_last;
        logic sc_last;
        logic pos_full;
    } t_sts;

    typedef logic [ACT_W-1:0] t_sig_tab [256];

    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [ACT_W-1:0] clamp255(logic [63:0] v);
        return (v > 64'd255) ? 8'hff : v[7:0];
    endfunction

    // e approximates exp(-k/16) in Q.32
    function automatic t_sig_tab build_sig();
        t_sig_tab     t;
        logic [127:0] e;
        logic [63:0]  d;
        logic [63:0]  v;
        e = 128'd1 << 32;
        for (int k = 0; k <= 128; k++) begin
            d = e[63:0] + (64'd1 << 32);
            if (k < 128) begin
                v = udiv64((64'd1 << 41) + d, d << 1);
                t[128 + k] = clamp255(v);
            end
            if (k > 0) begin
                v = udiv64((e[63:0] << 9) + d, d << 1);
                t[128 - k] = clamp255(v);
            end
            e = (e * {64'd0, EXP_STEP} + (128'd1 << 31)) >> 32;
        end
        return t;
    endfunction

    localparam t_sig_tab SIG_TABLE = build_sig();

endpackage

FILE: src/mlp_ctrl.sv
// Sequencer for the perceptron core: accepts transactions and steps the datapath phases.
// Depends on mlp_pkg.
module mlp_ctrl
    import mlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [KIND_W-1:0] i_kind,
    input  logic              i_last,
    input  t_sts              i_sts,
    input  logic              i_out_free,
    output logic              o_ready,
    output t_cmd              o_cmd
);

    t_state r_state, n_state;
    logic   r_last, n_last;
    logic   accept;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_kind == KIND_PIX) begin
                    n_last = i_last;
                    if (!i_sts.pos_full) begin
                        n_state = ST_MAC;
                    end else if (i_last) begin
                        n_state = ST_ACT;
                    end
                end
            end
            ST_MAC: begin
                if (i_sts.h_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = r_last ? ST_ACT : ST_IDLE;
            end
            ST_ACT: begin
                if (i_sts.h_last) begin
                    n_state = ST_SCORE;
                end
            end
            ST_SCORE: begin
                if (i_sts.sc_last) begin
                    n_state = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = accept;
        unique case (r_state)
            ST_MAC:   o_cmd.mac   = 1'b1;
            ST_ACT:   o_cmd.act   = 1'b1;
            ST_SCORE: o_cmd.score = 1'b1;
            ST_EMIT:  o_cmd.emit  = i_out_free;
            default:  o_cmd.mac   = 1'b0;
        endcase
    end

endmodule

FILE: src/mlp_dp.sv
// Datapath: weight memories, hidden accumulators, sigmoid stage, class score MAC and argmax.
// Depends on mlp_pkg.
module mlp_dp
    import mlp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [INDEX_W-1:0]  i_index,
    input  logic signed [W_W-1:0] i_weight,
    input  logic [PIX_W-1:0]    i_pixel,
    output t_sts                o_sts,
    output logic [CLS_W-1:0]    o_best_idx
);

    logic [W_W-1:0]   hw_mem  [HW_DEPTH];
    logic [W_W-1:0]   ow_mem  [OW_DEPTH];
    logic [SUM_W-1:0] sum_mem [HIDDEN];
    logic [ACT_W-1:0] act_mem [HIDDEN];

    logic [HID_W-1:0] r_h, r_h_d;
    logic [HW_AW-1:0] r_hrow;
    logic [POS_W-1:0] r_pos;
    logic [J_W-1:0]   r_j;
    logic [CLS_W-1:0] r_c, r_sc_c, r_bidx;
    logic [OW_AW-1:0] r_orow;
    logic             r_pv_mac, r_pv_act, r_pv_sc;
    logic [HIDDEN-1:0] r_sv;
    logic             r_sv_q, r_sc_first, r_sc_end;
    logic [PIX_W-1:0] r_px;
    logic [W_W-1:0]   r_hw_q, r_ow_q;
    logic [SUM_W-1:0] r_sum_q;
    logic [ACT_W-1:0] r_act_q;
    logic signed [SC_W-1:0] r_acc, r_best;

    logic [HW_AW-1:0] haddr;
    logic [OW_AW-1:0] oaddr;
    logic [J_W-1:0]   j_m1;
    logic [HID_W-1:0] act_ra;
    logic [SUM_W-1:0] sum_eff, mac_sum;
    logic signed [24:0] mac_prod, sc_prod;
    logic signed [SUM_W-1:0] act_s;
    logic signed [Q_W-1:0]   act_q;
    logic [ACT_W-1:0] act_idx;
    logic signed [SC_W-1:0] sc_term, acc_new;
    logic             hw_wr, ow_wr;

    assign hw_wr = i_cmd.load && i_kind == KIND_HW && 32'(i_index) < 32'(HW_DEPTH);
    assign ow_wr = i_cmd.load && i_kind == KIND_OW && 32'(i_index) < 32'(OW_DEPTH);

    assign haddr  = r_hrow + (i_cmd.act ? '0 : (HW_AW'(r_pos) + HW_AW'(1)));
    assign oaddr  = r_orow + OW_AW'(r_j);
    assign j_m1   = r_j - J_W'(1);
    assign act_ra = j_m1[HID_W-1:0];

    assign o_sts.h_last   = (r_h == HID_W'(HIDDEN - 1));
    assign o_sts.sc_last  = (r_j == J_W'(HIDDEN)) && (r_c == CLS_W'(CLASSES - 1));
    assign o_sts.pos_full = (r_pos == POS_W'(IN_DIM));
    assign o_best_idx     = r_bidx;

    always_ff @(posedge i_clk) begin
        if (hw_wr) begin
            hw_mem[i_index[HW_AW-1:0]] <= i_weight;
        end
        r_hw_q <= hw_mem[haddr];
    end

    always_ff @(posedge i_clk) begin
        if (ow_wr) begin
            ow_mem[i_index[OW_AW-1:0]] <= i_weight;
        end
        r_ow_q <= ow_mem[oaddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_pv_mac) begin
            sum_mem[r_h_d] <= mac_sum;
        end
        r_sum_q <= sum_mem[r_h];
        r_sv_q  <= r_sv[r_h];
    end

    always_ff @(posedge i_clk) begin
        if (r_pv_act) begin
            act_mem[r_h_d] <= act_idx;
        end
        r_act_q <= act_mem[act_ra];
    end

    // hidden MAC and activation
    assign sum_eff  = r_sv_q ? r_sum_q : '0;
    assign mac_prod = $signed(r_hw_q) * $signed({1'b0, r_px});
    assign mac_sum  = sum_eff + SUM_W'(mac_prod);
    assign act_s    = $signed(sum_eff + SUM_W'($signed(r_hw_q)));
    assign act_q    = act_s[SUM_W-1:4];

    always_comb begin
        if (act_q > Q_W'(127)) begin
            act_idx = SIG_TABLE[8'hff];
        end else if (act_q < Q_W'(-128)) begin
            act_idx = SIG_TABLE[8'h00];
        end else begin
            act_idx = SIG_TABLE[{~act_q[7], act_q[6:0]}];
        end
    end

    // class scores
    assign sc_prod = $signed(r_ow_q) * $signed({1'b0, r_act_q});
    assign sc_term = r_sc_first ? (SC_W'($signed(r_ow_q)) <<< 8) : SC_W'(sc_prod);
    assign acc_new = r_sc_first ? sc_term : r_acc + sc_term;

    always_ff @(posedge i_clk) begin
        r_h_d      <= r_h;
        r_sc_first <= (r_j == '0);
        r_sc_end   <= (r_j == J_W'(HIDDEN));
        r_sc_c     <= r_c;
        if (i_cmd.load) begin
            r_px <= i_pixel;
        end
        if (r_pv_sc) begin
            r_acc <= acc_new;
            if (r_sc_end && (r_sc_c == '0 || acc_new > r_best)) begin
                r_best <= acc_new;
                r_bidx <= r_sc_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h      <= '0;
            r_hrow   <= '0;
            r_pos    <= '0;
            r_j      <= '0;
            r_c      <= '0;
            r_orow   <= '0;
            r_pv_mac <= 1'b0;
            r_pv_act <= 1'b0;
            r_pv_sc  <= 1'b0;
            r_sv     <= '0;
        end else begin
            r_pv_mac <= i_cmd.mac;
            r_pv_act <= i_cmd.act;
            r_pv_sc  <= i_cmd.score;
            if (i_cmd.mac || i_cmd.act) begin
                if (o_sts.h_last) begin
                    r_h    <= '0;
                    r_hrow <= '0;
                end else begin
                    r_h    <= r_h + HID_W'(1);
                    r_hrow <= r_hrow + HW_AW'(IN_DIM + 1);
                end
            end
            if (i_cmd.mac && o_sts.h_last) begin
                r_pos <= r_pos + POS_W'(1);
            end
            if (i_cmd.score) begin
                if (r_j == J_W'(HIDDEN)) begin
                    r_j <= '0;
                    if (r_c == CLS_W'(CLASSES - 1)) begin
                        r_c    <= '0;
                        r_orow <= '0;
                    end else begin
                        r_c    <= r_c + CLS_W'(1);
                        r_orow <= r_orow + OW_AW'(HIDDEN + 1);
                    end
                end else begin
                    r_j <= r_j + J_W'(1);
                end
            end
            if (r_pv_mac) begin
                r_sv[r_h_d] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_pos <= '0;
                r_sv  <= '0;
            end
        end
    end

endmodule

FILE: src/mlp_two_layer_classifier_core.sv
// Top level of the two-layer perceptron classifier: controller, datapath and output register.
// Depends on mlp_pkg, mlp_ctrl, mlp_dp.
//
//  channel | direction | handshake            | payload
//  input   | in        | i_valid / o_ready    | i_kind, i_index, i_weight, i_pixel, i_last
//  result  | out       | o_valid / i_ready    | o_class_index
//
// A weight load is written to memory as it is accepted. A pixel runs one pass of the shared
// multiply-accumulate over the hidden accumulators plus a drain state. A last pixel adds
// a sigmoid lookup for each hidden unit and then the class scoring over every class.
// Reset clears control only; weight memories hold garbage until loaded.
// A stalled result holds the core in its emit state; a new transaction is taken once it leaves.
module mlp_two_layer_classifier_core
    import mlp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [INDEX_W-1:0]    i_index,
    input  logic signed [W_W-1:0] i_weight,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_last,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [CIDX_W-1:0]     o_class_index
);

    t_cmd             cmd;
    t_sts             sts;
    logic [CLS_W-1:0] best_idx;
    logic             out_free;
    logic             r_out_valid;
    logic [CIDX_W-1:0] r_out_idx;

    assign out_free      = !r_out_valid || i_ready;
    assign o_valid       = r_out_valid;
    assign o_class_index = r_out_idx;

    mlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_kind     (i_kind),
        .i_last     (i_last),
        .i_sts      (sts),
        .i_out_free (out_free),
        .o_ready    (o_ready),
        .o_cmd      (cmd)
    );

    mlp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_kind     (i_kind),
        .i_index    (i_index),
        .i_weight   (i_weight),
        .i_pixel    (i_pixel),
        .o_sts      (sts),
        .o_best_idx (best_idx)
    );

    always_ff @(posedge i_clk) begin
        if (cmd.emit) begin
            r_out_idx <= CIDX_W'(best_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!r_out_valid || i_ready))
        else $error("result overwrites a pending transaction");

    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.mac, cmd.act, cmd.score, cmd.emit, cmd.load}))
        else $error("more than one datapath phase active");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_valid)
        else $error("emitted result not presented");

endmodule
